@@ rtl/ttf_pkg.sv @@
package ttf_pkg;

  // default build
  localparam int unsigned SERIES_TERMS_DEF = 10;
  localparam int unsigned FRAC_BITS_DEF    = 30;

  // field widths
  localparam int unsigned DEG_W = 26;
  localparam int unsigned OP_W  = 3;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned ST_W  = 2;
  // quotient bits produced by the divider (one above the 32-bit result)
  localparam int unsigned QUO_W = 33;

  // pi as 314159265 / 10^8, over 180
  localparam logic [63:0] PI_NUM    = 64'd314159265;
  localparam logic [63:0] PI180_DEN = 64'd18000000000;

  // +-360 degrees in Q10.16
  localparam logic signed [DEG_W-1:0] ANGLE_MAX = 26'sd23592960;

  localparam logic [VAL_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] SAT_NEG = 32'h8000_0000;

  typedef enum logic [OP_W-1:0] {
    OP_SIN = 3'd0,
    OP_COS = 3'd1,
    OP_TAN = 3'd2,
    OP_CSC = 3'd3,
    OP_SEC = 3'd4,
    OP_COT = 3'd5
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_SAT   = 2'd1,
    ST_RANGE = 2'd2
  } st_e;

  // control that travels with every word
  typedef struct packed {
    logic            valid;
    logic [OP_W-1:0] op;
    logic            range_err;
    logic            op_err;
    logic            x_neg;
  } ctrl_t;

  // finishing info that rides along the divider
  typedef struct packed {
    logic [VAL_W-1:0] direct_val;
    logic             direct_sat;
    logic             q_neg;
    logic             den_zero;
    logic             num_neg;
  } fin_t;

  // round(pi/180 * 2^frac) by binary long division, elaboration only
  function automatic logic [63:0] rad_const(input int unsigned frac);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = PI_NUM;
    for (int unsigned i = 0; i < frac; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= PI180_DEN) begin
        r = r - PI180_DEN;
        q = q | 64'd1;
      end
    end
    if ((r << 1) >= PI180_DEN) begin
      q = q + 64'd1;
    end
    return q;
  endfunction

endpackage

@@ rtl/ttf_if.sv @@
// input word channel
interface ttf_in_if;
  logic                                valid;
  logic                                ready;
  logic [ttf_pkg::OP_W-1:0]            opcode;
  logic signed [ttf_pkg::DEG_W-1:0]    angle_degrees;

  modport source (output valid, opcode, angle_degrees, input ready);
  modport sink   (input valid, opcode, angle_degrees, output ready);
endinterface

// result word channel
interface ttf_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [ttf_pkg::VAL_W-1:0]    value;
  logic [ttf_pkg::ST_W-1:0]            status;

  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface

@@ rtl/ttf_mul.sv @@
// Unsigned multiplier, two stages: four half-width partial products, then the sum.
module ttf_mul #(
  parameter int unsigned A_W = 16,
  parameter int unsigned B_W = 16
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [A_W-1:0]     a_i,
  input  logic [B_W-1:0]     b_i,
  output logic [A_W+B_W-1:0] p_o
);

  localparam int unsigned AL = A_W / 2;
  localparam int unsigned AH = A_W - AL;
  localparam int unsigned BL = B_W / 2;
  localparam int unsigned BH = B_W - BL;
  localparam int unsigned PW = A_W + B_W;

  logic [AL+BL-1:0] ll_q;
  logic [AL+BH-1:0] lh_q;
  logic [AH+BL-1:0] hl_q;
  logic [AH+BH-1:0] hh_q;
  logic [PW-1:0]    p_d, p_q;

  // partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= (AL+BL)'(a_i[AL-1:0])   * (AL+BL)'(b_i[BL-1:0]);
      lh_q <= (AL+BH)'(a_i[AL-1:0])   * (AL+BH)'(b_i[B_W-1:BL]);
      hl_q <= (AH+BL)'(a_i[A_W-1:AL]) * (AH+BL)'(b_i[BL-1:0]);
      hh_q <= (AH+BH)'(a_i[A_W-1:AL]) * (AH+BH)'(b_i[B_W-1:BL]);
    end
  end

  // recombine
  always_comb begin
    p_d = PW'(ll_q) + (PW'(lh_q) << BL) + (PW'(hl_q) << AL) + (PW'(hh_q) << (AL + BL));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

@@ rtl/ttf_cell.sv @@
// One series cell: next sine and cosine term magnitudes, added into the running sums.
// Stages: 2 multiply, 1 round, 2 reciprocal multiply, 1 correct, 1 accumulate.
module ttf_cell #(
  parameter int unsigned FRAC_BITS = ttf_pkg::FRAC_BITS_DEF,
  parameter int unsigned K         = 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  ttf_pkg::ctrl_t               ctrl_i,
  input  logic [FRAC_BITS+5:0]         x2_i,
  input  logic [FRAC_BITS+7:0]         ts_i,
  input  logic [FRAC_BITS+7:0]         tc_i,
  input  logic signed [FRAC_BITS+10:0] ss_i,
  input  logic signed [FRAC_BITS+10:0] sc_i,
  output ttf_pkg::ctrl_t               ctrl_o,
  output logic [FRAC_BITS+5:0]         x2_o,
  output logic [FRAC_BITS+7:0]         ts_o,
  output logic [FRAC_BITS+7:0]         tc_o,
  output logic signed [FRAC_BITS+10:0] ss_o,
  output logic signed [FRAC_BITS+10:0] sc_o
);

  localparam int unsigned X2W = FRAC_BITS + 6;
  localparam int unsigned TW  = FRAC_BITS + 8;
  localparam int unsigned SW  = FRAC_BITS + 11;
  localparam int unsigned VW  = FRAC_BITS + 15;
  localparam int unsigned PW  = TW + X2W;
  localparam int unsigned LAT = 7;
  // divisors n*(n-1) for this term
  localparam int unsigned DS  = (2 * K + 1) * (2 * K);
  localparam int unsigned DC  = (2 * K) * (2 * K - 1);
  // floor(2^VW / d): quotient low by at most one for any VW-bit dividend
  localparam logic [VW-1:0] RS = VW'((64'd1 << VW) / DS);
  localparam logic [VW-1:0] RC = VW'((64'd1 << VW) / DC);
  localparam bit            SUBTRACT = (K % 2) == 1;

  ttf_pkg::ctrl_t         c_q   [LAT];
  logic [X2W-1:0]         x2_q  [LAT];
  logic signed [SW-1:0]   ss_q  [LAT-1];
  logic signed [SW-1:0]   sc_q  [LAT-1];

  logic [PW-1:0]          ps, pc;
  logic [VW-1:0]          vs_q, vc_q, vs1_q, vc1_q, vs2_q, vc2_q;
  logic [2*VW-1:0]        ms, mc;
  logic [TW-1:0]          qs, qc, ts_d, tc_d, ts6_q, tc6_q, ts7_q, tc7_q;
  logic [VW-1:0]          rs_w, rc_w;
  logic signed [SW-1:0]   ss7_q, sc7_q;

  // term times x^2
  ttf_mul #(.A_W(TW), .B_W(X2W)) u_mul_s (
    .clk_i(clk_i), .en_i(en_i), .a_i(ts_i), .b_i(x2_i), .p_o(ps)
  );
  ttf_mul #(.A_W(TW), .B_W(X2W)) u_mul_c (
    .clk_i(clk_i), .en_i(en_i), .a_i(tc_i), .b_i(x2_i), .p_o(pc)
  );

  // reciprocal multiply for the constant divide
  ttf_mul #(.A_W(VW), .B_W(VW)) u_rcp_s (
    .clk_i(clk_i), .en_i(en_i), .a_i(vs_q), .b_i(RS), .p_o(ms)
  );
  ttf_mul #(.A_W(VW), .B_W(VW)) u_rcp_c (
    .clk_i(clk_i), .en_i(en_i), .a_i(vc_q), .b_i(RC), .p_o(mc)
  );

  // estimate, then one correction step
  always_comb begin
    qs   = TW'(ms >> VW);
    qc   = TW'(mc >> VW);
    rs_w = vs2_q - VW'(qs) * VW'(DS);
    rc_w = vc2_q - VW'(qc) * VW'(DC);
    ts_d = (rs_w >= VW'(DS)) ? qs + TW'(1) : qs;
    tc_d = (rc_w >= VW'(DC)) ? qc + TW'(1) : qc;
  end

  // control delay line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT; i++) begin
        c_q[i] <= '0;
      end
    end else if (en_i) begin
      c_q[0] <= ctrl_i;
      for (int i = 1; i < LAT; i++) begin
        c_q[i] <= c_q[i-1];
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x2_q[0] <= x2_i;
      for (int i = 1; i < LAT; i++) begin
        x2_q[i] <= x2_q[i-1];
      end
      ss_q[0] <= ss_i;
      sc_q[0] <= sc_i;
      for (int i = 1; i < LAT - 1; i++) begin
        ss_q[i] <= ss_q[i-1];
        sc_q[i] <= sc_q[i-1];
      end
      // round the product to FRAC_BITS, add half the divisor
      vs_q  <= VW'((ps + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS) + VW'(DS / 2);
      vc_q  <= VW'((pc + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS) + VW'(DC / 2);
      vs1_q <= vs_q;
      vc1_q <= vc_q;
      vs2_q <= vs1_q;
      vc2_q <= vc1_q;
      ts6_q <= ts_d;
      tc6_q <= tc_d;
      ts7_q <= ts6_q;
      tc7_q <= tc6_q;
      // signs alternate term by term
      if (SUBTRACT) begin
        ss7_q <= ss_q[LAT-2] - SW'(ts6_q);
        sc7_q <= sc_q[LAT-2] - SW'(tc6_q);
      end else begin
        ss7_q <= ss_q[LAT-2] + SW'(ts6_q);
        sc7_q <= sc_q[LAT-2] + SW'(tc6_q);
      end
    end
  end

  assign ctrl_o = c_q[LAT-1];
  assign x2_o   = x2_q[LAT-1];
  assign ts_o   = ts7_q;
  assign tc_o   = tc7_q;
  assign ss_o   = ss7_q;
  assign sc_o   = sc7_q;

endmodule

@@ rtl/ttf_div.sv @@
// Restoring divider, one quotient bit per stage.
// Divides (num << 16) + den/2 by den; first stage flags a quotient of 2^33 or more.
module ttf_div #(
  parameter int unsigned NW = 41
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  ttf_pkg::ctrl_t              ctrl_i,
  input  ttf_pkg::fin_t               fin_i,
  input  logic [NW-1:0]               nm_i,
  input  logic [NW-1:0]               dm_i,
  output ttf_pkg::ctrl_t              ctrl_o,
  output ttf_pkg::fin_t               fin_o,
  output logic [ttf_pkg::QUO_W-1:0]   q_o,
  output logic                        ovf_o
);

  localparam int unsigned QW  = ttf_pkg::QUO_W;
  localparam int unsigned NNW = NW + 17;
  localparam int unsigned CW  = NNW + QW;
  localparam int unsigned NST = QW + 1;

  ttf_pkg::ctrl_t   c_q [NST];
  ttf_pkg::fin_t    f_q [NST];
  logic [NNW-1:0]   r_q [NST];
  logic [NW-1:0]    d_q [NST];
  logic [QW-1:0]    q_q [NST];
  logic             o_q [NST];

  logic [NNW-1:0]   n0;
  logic             ovf0;

  // dividend with rounding, overflow check
  always_comb begin
    n0   = (NNW'(nm_i) << 16) + NNW'(dm_i >> 1);
    ovf0 = CW'(n0) >= (CW'(dm_i) << QW);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NST; i++) begin
        c_q[i] <= '0;
      end
    end else if (en_i) begin
      c_q[0] <= ctrl_i;
      for (int i = 1; i < NST; i++) begin
        c_q[i] <= c_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_q[0] <= fin_i;
      r_q[0] <= n0;
      d_q[0] <= dm_i;
      q_q[0] <= '0;
      o_q[0] <= ovf0;
    end
  end

  // bit stages, most significant quotient bit first
  for (genvar j = 1; j < NST; j++) begin : g_bit
    localparam int unsigned B = QW - j;
    logic [CW-1:0] sub;
    logic          ge;

    assign sub = CW'(d_q[j-1]) << B;
    assign ge  = CW'(r_q[j-1]) >= sub;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        f_q[j] <= f_q[j-1];
        d_q[j] <= d_q[j-1];
        o_q[j] <= o_q[j-1];
        r_q[j] <= ge ? NNW'(CW'(r_q[j-1]) - sub) : r_q[j-1];
        q_q[j] <= q_q[j-1] | (QW'(ge) << B);
      end
    end
  end

  assign ctrl_o = c_q[NST-1];
  assign fin_o  = f_q[NST-1];
  assign q_o    = q_q[NST-1];
  assign ovf_o  = o_q[NST-1];

endmodule

@@ rtl/taylor_trig_function_unit_top.sv @@
// Channel  Dir  Handshake     Word
// in_i     in   valid/ready   opcode[2:0], angle_degrees[25:0] signed Q10.16 degrees
// out_o    out  valid/ready   value[31:0] signed Q16.16, status[1:0]
//
// One word accepted per cycle while ready is high, one result per word, in order.
// Stages: 7 in the front end, 7 per series cell, 2 finishing stages,
// 34 divider stages and 1 output register.
// All stages advance together; ready is low only while a result sits in the
// output register and the sink holds ready low.
// Reset clears the valid bits of every stage; no startup sequence.
module taylor_trig_function_unit_top #(
  parameter int unsigned SERIES_TERMS = ttf_pkg::SERIES_TERMS_DEF,
  parameter int unsigned FRAC_BITS    = ttf_pkg::FRAC_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  ttf_in_if.sink    in_i,
  ttf_out_if.source out_o
);

  localparam int unsigned DW   = ttf_pkg::DEG_W;
  localparam int unsigned RADW = FRAC_BITS - 4;
  localparam int unsigned DPW  = DW + RADW;
  localparam int unsigned XW   = FRAC_BITS + 3;
  localparam int unsigned X2W  = FRAC_BITS + 6;
  localparam int unsigned TW   = FRAC_BITS + 8;
  localparam int unsigned SW   = FRAC_BITS + 11;
  localparam int unsigned SH   = FRAC_BITS - 16;
  localparam int unsigned FE   = 7;
  localparam int unsigned VW   = ttf_pkg::VAL_W;
  localparam int unsigned QW   = ttf_pkg::QUO_W;

  localparam logic [RADW-1:0]     RAD = RADW'(ttf_pkg::rad_const(FRAC_BITS));
  localparam logic signed [SW-1:0] ONE = SW'(1) << FRAC_BITS;

  logic en;

  // ---------------- front end: radians and x^2 ----------------
  ttf_pkg::ctrl_t          fc_q [FE];
  ttf_pkg::ctrl_t          fc_d;
  logic [DW-1:0]           degm_q;
  logic [DPW-1:0]          pd;
  logic [XW-1:0]           xm_q, xm4_q, xm5_q, xm6_q;
  logic [2*XW-1:0]         pxx;
  logic [X2W-1:0]          x2_q;

  assign en       = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  always_comb begin
    fc_d.valid     = in_i.valid;
    fc_d.op        = in_i.opcode;
    fc_d.range_err = (in_i.angle_degrees > ttf_pkg::ANGLE_MAX) ||
                     (in_i.angle_degrees < -ttf_pkg::ANGLE_MAX);
    fc_d.op_err    = in_i.opcode > ttf_pkg::OP_COT;
    fc_d.x_neg     = in_i.angle_degrees[DW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FE; i++) begin
        fc_q[i] <= '0;
      end
    end else if (en) begin
      fc_q[0] <= fc_d;
      for (int i = 1; i < FE; i++) begin
        fc_q[i] <= fc_q[i-1];
      end
    end
  end

  ttf_mul #(.A_W(DW), .B_W(RADW)) u_mul_rad (
    .clk_i(clk_i), .en_i(en), .a_i(degm_q), .b_i(RAD), .p_o(pd)
  );

  ttf_mul #(.A_W(XW), .B_W(XW)) u_mul_sq (
    .clk_i(clk_i), .en_i(en), .a_i(xm_q), .b_i(xm_q), .p_o(pxx)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      degm_q <= in_i.angle_degrees[DW-1] ? DW'(-in_i.angle_degrees)
                                          : DW'(in_i.angle_degrees);
      xm_q   <= XW'((pd + (DPW'(1) << 15)) >> 16);
      xm4_q  <= xm_q;
      xm5_q  <= xm4_q;
      xm6_q  <= xm5_q;
      x2_q   <= X2W'((pxx + ((2*XW)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
    end
  end

  // ---------------- series cells ----------------
  ttf_pkg::ctrl_t        ch_c  [SERIES_TERMS];
  logic [X2W-1:0]        ch_x2 [SERIES_TERMS];
  logic [TW-1:0]         ch_ts [SERIES_TERMS];
  logic [TW-1:0]         ch_tc [SERIES_TERMS];
  logic signed [SW-1:0]  ch_ss [SERIES_TERMS];
  logic signed [SW-1:0]  ch_sc [SERIES_TERMS];

  // first terms: x and 1
  assign ch_c[0]  = fc_q[FE-1];
  assign ch_x2[0] = x2_q;
  assign ch_ts[0] = TW'(xm6_q);
  assign ch_tc[0] = TW'(ONE);
  assign ch_ss[0] = SW'(xm6_q);
  assign ch_sc[0] = ONE;

  for (genvar g = 1; g < SERIES_TERMS; g++) begin : g_cell
    ttf_cell #(.FRAC_BITS(FRAC_BITS), .K(g)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .ctrl_i(ch_c[g-1]),
      .x2_i  (ch_x2[g-1]),
      .ts_i  (ch_ts[g-1]),
      .tc_i  (ch_tc[g-1]),
      .ss_i  (ch_ss[g-1]),
      .sc_i  (ch_sc[g-1]),
      .ctrl_o(ch_c[g]),
      .x2_o  (ch_x2[g]),
      .ts_o  (ch_ts[g]),
      .tc_o  (ch_tc[g]),
      .ss_o  (ch_ss[g]),
      .sc_o  (ch_sc[g])
    );
  end

  // ---------------- finish 1: sign and operand select ----------------
  ttf_pkg::ctrl_t        c1_q, c2_q;
  logic signed [SW-1:0]  s_v, c_v, num_d, den_d, dir_d;
  logic signed [SW-1:0]  num1_q, den1_q, dir1_q;

  always_comb begin
    s_v   = ch_c[SERIES_TERMS-1].x_neg ? -ch_ss[SERIES_TERMS-1] : ch_ss[SERIES_TERMS-1];
    c_v   = ch_sc[SERIES_TERMS-1];
    num_d = s_v;
    den_d = c_v;
    dir_d = s_v;
    unique case (ch_c[SERIES_TERMS-1].op)
      ttf_pkg::OP_SIN: dir_d = s_v;
      ttf_pkg::OP_COS: dir_d = c_v;
      ttf_pkg::OP_TAN: begin
        num_d = s_v;
        den_d = c_v;
      end
      ttf_pkg::OP_CSC: begin
        num_d = ONE;
        den_d = s_v;
      end
      ttf_pkg::OP_SEC: begin
        num_d = ONE;
        den_d = c_v;
      end
      ttf_pkg::OP_COT: begin
        num_d = c_v;
        den_d = s_v;
      end
      default: ;
    endcase
  end

  // ---------------- finish 2: magnitudes, Q16.16 for sine and cosine ----------------
  logic [SW-1:0]    nm_d, dm_d, dmag;
  logic [SW+1:0]    r2, rr;
  logic [VW-1:0]    rr32;
  logic             dneg;
  ttf_pkg::fin_t    fin_d, fin2_q;
  logic [SW-1:0]    nm2_q, dm2_q;

  always_comb begin
    nm_d = num1_q[SW-1] ? SW'(-num1_q) : SW'(num1_q);
    dm_d = den1_q[SW-1] ? SW'(-den1_q) : SW'(den1_q);
    dmag = dir1_q[SW-1] ? SW'(-dir1_q) : SW'(dir1_q);
    dneg = dir1_q[SW-1];
    // round half away from zero on the magnitude
    r2   = (SW+2)'({dmag, 1'b0}) >> SH;
    rr   = (r2 + (SW+2)'(1)) >> 1;
    rr32 = VW'(rr);
    fin_d.direct_sat = 1'b0;
    if (!dneg && 64'(rr) > 64'(ttf_pkg::SAT_POS)) begin
      fin_d.direct_val = ttf_pkg::SAT_POS;
      fin_d.direct_sat = 1'b1;
    end else if (dneg && 64'(rr) > 64'(ttf_pkg::SAT_NEG)) begin
      fin_d.direct_val = ttf_pkg::SAT_NEG;
      fin_d.direct_sat = 1'b1;
    end else begin
      fin_d.direct_val = dneg ? -rr32 : rr32;
    end
    fin_d.num_neg  = num1_q[SW-1];
    fin_d.q_neg    = num1_q[SW-1] != den1_q[SW-1];
    fin_d.den_zero = den1_q == '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
    end else if (en) begin
      c1_q <= ch_c[SERIES_TERMS-1];
      c2_q <= c1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num1_q <= num_d;
      den1_q <= den_d;
      dir1_q <= dir_d;
      fin2_q <= fin_d;
      nm2_q  <= nm_d;
      dm2_q  <= dm_d;
    end
  end

  // ---------------- quotient ----------------
  ttf_pkg::ctrl_t  dc;
  ttf_pkg::fin_t   df;
  logic [QW-1:0]   dq;
  logic            dovf;

  ttf_div #(.NW(SW)) u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .ctrl_i(c2_q),
    .fin_i (fin2_q),
    .nm_i  (nm2_q),
    .dm_i  (dm2_q),
    .ctrl_o(dc),
    .fin_o (df),
    .q_o   (dq),
    .ovf_o (dovf)
  );

  // ---------------- result select and output register ----------------
  logic [VW-1:0]       val_d;
  ttf_pkg::st_e        st_d;
  logic                outv_q;
  logic signed [VW-1:0] val_q;
  ttf_pkg::st_e        st_q;

  always_comb begin
    val_d = '0;
    st_d  = ttf_pkg::ST_OK;
    priority if (dc.range_err) begin
      st_d = ttf_pkg::ST_RANGE;
    end else if (dc.op_err) begin
      st_d = ttf_pkg::ST_SAT;
    end else if (dc.op == ttf_pkg::OP_SIN || dc.op == ttf_pkg::OP_COS) begin
      val_d = df.direct_val;
      st_d  = df.direct_sat ? ttf_pkg::ST_SAT : ttf_pkg::ST_OK;
    end else if (df.den_zero) begin
      val_d = df.num_neg ? ttf_pkg::SAT_NEG : ttf_pkg::SAT_POS;
      st_d  = ttf_pkg::ST_SAT;
    end else if (!df.q_neg && (dovf || dq > QW'(ttf_pkg::SAT_POS))) begin
      val_d = ttf_pkg::SAT_POS;
      st_d  = ttf_pkg::ST_SAT;
    end else if (df.q_neg && (dovf || dq > QW'(ttf_pkg::SAT_NEG))) begin
      val_d = ttf_pkg::SAT_NEG;
      st_d  = ttf_pkg::ST_SAT;
    end else begin
      val_d = df.q_neg ? -VW'(dq) : VW'(dq);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outv_q <= 1'b0;
    end else if (en) begin
      outv_q <= dc.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      val_q <= val_d;
      st_q  <= st_d;
    end
  end

  assign out_o.valid  = outv_q;
  assign out_o.value  = val_q;
  assign out_o.status = st_q;

endmodule

@@ rtl/ttf_chk.sv @@
// Port-level checks on the trig unit.
module ttf_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [ttf_pkg::VAL_W-1:0]     value_i,
  input logic [ttf_pkg::ST_W-1:0]      status_i
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a stalled result keeps its word
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(value_i) && $stable(status_i))
    else $error("result word changed while stalled");

  // no unused status code
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (status_i == ttf_pkg::ST_OK) || (status_i == ttf_pkg::ST_SAT) ||
                    (status_i == ttf_pkg::ST_RANGE))
    else $error("undefined status code");

  // angle out of range carries a zero value
  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ttf_pkg::ST_RANGE |-> value_i == '0)
    else $error("range error with nonzero value");

  // empty output register never blocks the input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

endmodule

bind taylor_trig_function_unit_top ttf_chk u_ttf_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .value_i    (out_o.value),
  .status_i   (out_o.status)
);

@@ test/tb_taylor_trig_function_unit_top.sv @@
`timescale 1ns / 1ps

module tb_taylor_trig_function_unit_top;

  localparam int unsigned TERMS     = 10;
  localparam int unsigned FBITS     = 30;
  localparam int          LATENCY   = 7 * TERMS + 37;
  localparam int          STALL_MAX = 5000;
  localparam int          RAND_WORDS = 540;
  localparam int          ANGLE_LIM = 23592960;

  typedef struct {
    logic [ttf_pkg::VAL_W-1:0] value;
    logic [ttf_pkg::ST_W-1:0]  status;
  } trig_result_t;

  logic clk_i;
  logic rst_ni;

  ttf_in_if  in_if ();
  ttf_out_if out_if ();

  taylor_trig_function_unit_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  trig_result_t trig_expected_q[$];
  int unsigned  mismatches;
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;
  int unsigned  hold_off_cycles;
  int unsigned  quiet_cycles;
  logic [63:0]  deg_to_rad;

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // fixed-point helpers for the trig predictor
  function automatic logic [63:0] mag64(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint signed64(input logic neg, input logic [63:0] m);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  // a*b >> FBITS, round to nearest, ties away from zero
  function automatic longint fx_mul(input longint a, input longint b);
    logic [127:0] p;
    p = {64'd0, mag64(a)} * {64'd0, mag64(b)};
    p = p + (128'd1 << (FBITS - 1));
    return signed64((a < 0) != (b < 0), p[FBITS +: 64]);
  endfunction

  function automatic longint taylor_sum(input longint x, input logic odd);
    longint      x2;
    longint      term;
    longint      sum;
    logic [63:0] n;
    logic [63:0] m;
    x2   = fx_mul(x, x);
    term = odd ? x : (longint'(1) << FBITS);
    sum  = term;
    for (int k = 1; k < TERMS; k++) begin
      n    = odd ? 64'(2 * k + 1) : 64'(2 * k);
      term = fx_mul(term, x2);
      m    = (mag64(term) + (n * (n - 1)) / 2) / (n * (n - 1));
      term = signed64(term < 0, m);
      if (k & 1) sum = sum - term;
      else sum = sum + term;
    end
    return sum;
  endfunction

  function automatic logic [31:0] sat_q16(input logic neg, input logic [63:0] m,
                                          inout logic [1:0] st);
    if (!neg && m > 64'h7FFF_FFFF) begin
      st = ttf_pkg::ST_SAT;
      return ttf_pkg::SAT_POS;
    end
    if (neg && m > 64'h8000_0000) begin
      st = ttf_pkg::ST_SAT;
      return ttf_pkg::SAT_NEG;
    end
    return 32'(signed64(neg, m));
  endfunction

  function automatic logic [31:0] fx_to_q16(input longint v, inout logic [1:0] st);
    logic [63:0] m;
    m = (mag64(v) + (64'd1 << (FBITS - 17))) >> (FBITS - 16);
    return sat_q16(v < 0, m, st);
  endfunction

  function automatic logic [31:0] fx_ratio(input longint num, input longint den,
                                           inout logic [1:0] st);
    logic [63:0] nm;
    logic [63:0] dm;
    nm = mag64(num);
    dm = mag64(den);
    if (den == 0) begin
      st = ttf_pkg::ST_SAT;
      return num < 0 ? ttf_pkg::SAT_NEG : ttf_pkg::SAT_POS;
    end
    return sat_q16((num < 0) != (den < 0), ((nm << 16) + dm / 2) / dm, st);
  endfunction

  // expected word for one angle/opcode pair
  function automatic trig_result_t trig_predict(input logic [2:0] op,
                                                input logic signed [25:0] deg);
    trig_result_t r;
    longint       d;
    longint       x;
    longint       s;
    longint       c;
    longint       one;
    logic [1:0]   st;
    d   = longint'(deg);
    one = longint'(1) << FBITS;
    st  = ttf_pkg::ST_OK;
    r.value = '0;
    if (d > ANGLE_LIM || d < -ANGLE_LIM) begin
      r.status = ttf_pkg::ST_RANGE;
      return r;
    end
    if (op > ttf_pkg::OP_COT) begin
      r.status = ttf_pkg::ST_SAT;
      return r;
    end
    x = signed64(d < 0, (mag64(d) * deg_to_rad + (64'd1 << 15)) >> 16);
    s = taylor_sum(x, 1'b1);
    c = taylor_sum(x, 1'b0);
    case (op)
      ttf_pkg::OP_SIN: r.value = fx_to_q16(s, st);
      ttf_pkg::OP_COS: r.value = fx_to_q16(c, st);
      ttf_pkg::OP_TAN: r.value = fx_ratio(s, c, st);
      ttf_pkg::OP_CSC: r.value = fx_ratio(one, s, st);
      ttf_pkg::OP_SEC: r.value = fx_ratio(one, c, st);
      default: r.value = fx_ratio(c, s, st);
    endcase
    r.status = st;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // send one word; valid stays high across back-to-back words
  task automatic send_word(input logic [2:0] op, input logic signed [25:0] deg);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.opcode        <= op;
    in_if.angle_degrees <= deg;
    do @(posedge clk_i); while (!in_if.ready);
    trig_expected_q.push_back(trig_predict(op, deg));
    @(negedge clk_i);
  endtask

  task automatic stop_sending();
    in_if.valid <= 1'b0;
  endtask

  function automatic logic signed [25:0] rand_angle();
    int a;
    case ($urandom_range(9))
      0: return 26'($urandom());
      1: return $urandom_range(1) ? 26'sd23592960 : -26'sd23592960;
      default: begin
        a = int'($urandom_range(2 * ANGLE_LIM)) - ANGLE_LIM;
        return 26'(a);
      end
    endcase
  endfunction

  function automatic logic [2:0] rand_op();
    return ($urandom_range(15) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
  endfunction

  // extremes, each function, zero divisors, out of range, unused opcodes
  task automatic test_directed();
    logic signed [25:0] angles [8];
    angles = '{26'sd0, 26'sd23592960, -26'sd23592960, 26'sd5898240,
               26'sd11796480, -26'sd5898240, 26'sd23592961, 26'sh200_0000};
    foreach (angles[i]) begin
      for (int op = ttf_pkg::OP_SIN; op <= ttf_pkg::OP_COT; op++) begin
        if (i < 3 || op[0] == 1'b1 || op == ttf_pkg::OP_TAN) send_word(3'(op), angles[i]);
      end
    end
    send_word(3'd6, 26'sd1);
    send_word(3'd7, 26'sh1FF_FFFF);
    stop_sending();
  endtask

  task automatic test_random(input int unsigned words);
    repeat (words) send_word(rand_op(), rand_angle());
    stop_sending();
  endtask

  // no idling on either side
  task automatic test_streaming();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (200) send_word(rand_op(), rand_angle());
    stop_sending();
    send_idle_pct = 32;
    recv_idle_pct = 32;
  endtask

  // sink holds off long enough for the pipeline to fill and stall the input
  task automatic test_backpressure();
    hold_off_cycles = 3 * LATENCY;
    repeat (2 * LATENCY) send_word(rand_op(), rand_angle());
    stop_sending();
  endtask

  // sink ready, with random idling and the hold-off
  always @(negedge clk_i) begin
    if (hold_off_cycles != 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_if.ready    <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result check
  always @(posedge clk_i) begin
    trig_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (trig_expected_q.size() == 0) begin
        report_mismatch("unexpected word", out_if.value, 32'd0);
      end else begin
        want = trig_expected_q.pop_front();
        if (out_if.value !== want.value) report_mismatch("value", out_if.value, want.value);
        if (out_if.status !== want.status)
          report_mismatch("status", 32'(out_if.status), 32'(want.status));
      end
    end
  end

  // watchdog on cycles with no accepted word on either side
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_MAX) begin
      $display("[taylor_trig_function_unit_top] ERROR");
      $finish;
    end
  end

  initial begin
    logic [127:0] n;
    clk_i               = 1'b0;
    rst_ni              = 1'b0;
    in_if.valid         = 1'b0;
    in_if.opcode        = '0;
    in_if.angle_degrees = '0;
    out_if.ready        = 1'b0;
    mismatches          = 0;
    quiet_cycles        = 0;
    hold_off_cycles     = 0;
    send_idle_pct       = 32;
    recv_idle_pct       = 32;
    // pi/180 in Q.FBITS, rounded
    n = 128'd314159265 << FBITS;
    deg_to_rad = 64'(n / 128'd18000000000);
    if (2 * (n % 128'd18000000000) >= 128'd18000000000) deg_to_rad = deg_to_rad + 1;

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random(RAND_WORDS / 2);
    test_streaming();
    test_backpressure();
    test_random(RAND_WORDS / 2);

    while (trig_expected_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("[taylor_trig_function_unit_top] OK");
    end else begin
      $display("[taylor_trig_function_unit_top] ERROR");
    end
    $finish;
  end

endmodule
